// ===== hw/rtl/sdse_pkg.sv =====
// sdse_pkg: shared types and constants of the sd spi sector engine
// no dependencies; used by the item interfaces and every module
`timescale 1ns / 1ps

package sdse_pkg;

  // operation codes
  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // completion status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_CARD   = 3'd1;
  localparam logic [2:0] ST_RESET_REJ = 3'd2;
  localparam logic [2:0] ST_INIT_FAIL = 3'd3;
  localparam logic [2:0] ST_READ_REJ  = 3'd4;
  localparam logic [2:0] ST_CARD_ERR  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_RESET_TRIES = 2'd0;
  localparam logic [1:0] REG_INIT_TRIES  = 2'd1;
  localparam logic [1:0] REG_TOKEN_TRIES = 2'd2;
  localparam logic [1:0] REG_POLL_BYTES  = 2'd3;

  // bus bytes
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN = 8'hFE;
  localparam logic [7:0] BYTE_CMD   = 8'h40;
  localparam logic [7:0] BYTE_CRC   = 8'h95;
  localparam logic [7:0] BYTE_R1_OK = 8'h00;
  localparam logic [7:0] BYTE_R1_IDLE = 8'h01;

  // command numbers
  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_INIT    = 6'd1;
  localparam logic [5:0] CMD_STATUS  = 6'd13;
  localparam logic [5:0] CMD_READ    = 6'd17;
  localparam logic [5:0] CMD_WRITE   = 6'd24;

  typedef struct packed {
    logic        kind;
    logic [1:0]  operation;
    logic [22:0] sector;
    logic [9:0]  keep_length;
    logic [7:0]  card_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  send_byte;
    logic        send_valid;
    logic        chip_select;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic [8:0]  read_index;
    logic        write_taken;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] card_status;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  reset_tries;
    logic [15:0] init_tries;
    logic [15:0] token_tries;
    logic [4:0]  poll_bytes;
  } cfg_t;

  // command frame byte at a given position
  function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [5:0] cmd,
                                            input logic [31:0] addr);
    logic [7:0] b;
    case (pos)
      3'd1: b = BYTE_CMD | {2'b00, cmd};
      3'd2: b = addr[31:24];
      3'd3: b = addr[23:16];
      3'd4: b = addr[15:8];
      3'd5: b = addr[7:0];
      3'd6: b = BYTE_CRC;
      default: b = BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/sdse_in_if.sv =====
// sdse_in_if: input item channel, valid/ready with payload
// depends on sdse_pkg
`timescale 1ns / 1ps

interface sdse_in_if;
  logic               valid;
  logic               ready;
  sdse_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sdse_out_if.sv =====
// sdse_out_if: result item channel, valid/ready with payload
// depends on sdse_pkg
`timescale 1ns / 1ps

interface sdse_out_if;
  logic                valid;
  logic                ready;
  sdse_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sdse_cfg_if.sv =====
// sdse_cfg_if: configuration write channel, register index and data
// no dependencies
`timescale 1ns / 1ps

interface sdse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sdse_seq.sv =====
// sdse_seq: protocol sequencer state and next-byte decision for one transfer
// depends on sdse_pkg
`timescale 1ns / 1ps

module sdse_seq #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  sdse_pkg::in_item_t  item,
  input  sdse_pkg::cfg_t      cfg,
  output sdse_pkg::out_item_t res
);

  localparam int CW = $clog2(BLOCK_BYTES);
  localparam int KW = (CW > 10) ? CW : 10;
  localparam logic [KW-1:0] LAST_BYTE = KW'(BLOCK_BYTES - 1);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_DUMMY    = 4'd1;
  localparam logic [3:0] PH_FRAME    = 4'd2;
  localparam logic [3:0] PH_POLL     = 4'd3;
  localparam logic [3:0] PH_TOKEN    = 4'd4;
  localparam logic [3:0] PH_DATA_IN  = 4'd5;
  localparam logic [3:0] PH_WTOKEN   = 4'd6;
  localparam logic [3:0] PH_DATA_OUT = 4'd7;
  localparam logic [3:0] PH_TAIL     = 4'd8;
  localparam logic [3:0] PH_BUSY     = 4'd9;
  localparam logic [3:0] PH_STAT_LOW = 4'd10;

  logic [3:0]    phase_r, phase_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [2:0]    fpos_r, fpos_nxt;
  logic [CW-1:0] bcount_r, bcount_nxt;
  logic [15:0]   retry_r, retry_nxt;
  logic [3:0]    poll_r, poll_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [9:0]    kept_r, kept_nxt;
  logic [7:0]    first_r, first_nxt;
  logic          second_r, second_nxt;

  logic [4:0]    poll_lim;
  logic          poll_last;
  logic [5:0]    cmd;
  logic [KW-1:0] bcount_w;
  logic [7:0]    r;
  logic [15:0]   sword;

  // clamp poll length to 1..16
  always_comb begin
    if (cfg.poll_bytes == 5'd0) poll_lim = 5'd1;
    else if (cfg.poll_bytes > 5'd16) poll_lim = 5'd16;
    else poll_lim = cfg.poll_bytes;
  end

  assign poll_last = ({1'b0, poll_r} + 5'd1) >= poll_lim;
  assign bcount_w  = KW'(bcount_r);
  assign r         = item.card_byte;
  assign sword     = {first_r, r};

  // command for the current frame
  always_comb begin
    case (op_r)
      sdse_pkg::OP_INIT:  cmd = second_r ? sdse_pkg::CMD_INIT : sdse_pkg::CMD_GO_IDLE;
      sdse_pkg::OP_READ:  cmd = sdse_pkg::CMD_READ;
      sdse_pkg::OP_WRITE: cmd = sdse_pkg::CMD_WRITE;
      default:            cmd = sdse_pkg::CMD_STATUS;
    endcase
  end

  // next state and result
  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    fpos_nxt   = fpos_r;
    bcount_nxt = bcount_r;
    retry_nxt  = retry_r;
    poll_nxt   = poll_r;
    addr_nxt   = addr_r;
    kept_nxt   = kept_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    res        = '0;
    if (item.kind == sdse_pkg::KIND_START) begin
      if (phase_r != PH_IDLE) begin
        res.chip_select = 1'b1;
      end else begin
        op_nxt     = item.operation;
        second_nxt = 1'b0;
        retry_nxt  = '0;
        poll_nxt   = '0;
        bcount_nxt = '0;
        first_nxt  = sdse_pkg::BYTE_IDLE;
        addr_nxt   = (item.operation == sdse_pkg::OP_READ ||
                      item.operation == sdse_pkg::OP_WRITE) ?
                     32'(32'(item.sector) * 32'(BLOCK_BYTES)) : 32'd0;
        kept_nxt   = (item.operation == sdse_pkg::OP_READ) ? item.keep_length : 10'd0;
        res.send_byte  = sdse_pkg::BYTE_IDLE;
        res.send_valid = 1'b1;
        if (item.operation == sdse_pkg::OP_INIT) begin
          phase_nxt = PH_DUMMY;
        end else begin
          phase_nxt       = PH_FRAME;
          fpos_nxt        = '0;
          res.chip_select = 1'b1;
        end
      end
    end else begin
      case (phase_r)
        PH_DUMMY: begin
          phase_nxt = PH_FRAME;
          fpos_nxt  = '0;
          res.send_byte = sdse_pkg::BYTE_IDLE;
          res.send_valid = 1'b1;
          res.chip_select = 1'b1;
        end
        PH_FRAME: begin
          res.send_valid = 1'b1;
          res.chip_select = 1'b1;
          if (fpos_r < 3'd7) begin
            fpos_nxt = fpos_r + 3'd1;
            res.send_byte = sdse_pkg::frame_byte(fpos_r + 3'd1, cmd, addr_r);
          end else begin
            phase_nxt = PH_POLL;
            poll_nxt  = '0;
            res.send_byte = sdse_pkg::BYTE_IDLE;
          end
        end
        PH_POLL: begin
          if (r != sdse_pkg::BYTE_IDLE || poll_last) begin
            first_nxt = r;
            case (op_r)
              sdse_pkg::OP_INIT: begin
                if (!second_r) begin
                  if (r == sdse_pkg::BYTE_R1_IDLE) begin
                    second_nxt = 1'b1;
                    retry_nxt  = '0;
                    phase_nxt  = PH_FRAME;
                    fpos_nxt   = '0;
                    res.send_byte = sdse_pkg::BYTE_IDLE;
                    res.send_valid = 1'b1;
                    res.chip_select = 1'b1;
                  end else if (retry_r < {6'd0, cfg.reset_tries}) begin
                    retry_nxt = retry_r + 16'd1;
                    phase_nxt = PH_FRAME;
                    fpos_nxt  = '0;
                    res.send_byte = sdse_pkg::BYTE_IDLE;
                    res.send_valid = 1'b1;
                    res.chip_select = 1'b1;
                  end else begin
                    phase_nxt = PH_IDLE;
                    res.done_res = 1'b1;
                    res.status = (r == sdse_pkg::BYTE_IDLE) ? sdse_pkg::ST_NO_CARD :
                                                              sdse_pkg::ST_RESET_REJ;
                  end
                end else begin
                  if (r == sdse_pkg::BYTE_R1_IDLE && retry_r < cfg.init_tries) begin
                    retry_nxt = retry_r + 16'd1;
                    phase_nxt = PH_FRAME;
                    fpos_nxt  = '0;
                    res.send_byte = sdse_pkg::BYTE_IDLE;
                    res.send_valid = 1'b1;
                    res.chip_select = 1'b1;
                  end else begin
                    phase_nxt = PH_IDLE;
                    res.done_res = 1'b1;
                    res.status = (r == sdse_pkg::BYTE_R1_OK) ? sdse_pkg::ST_OK :
                                                               sdse_pkg::ST_INIT_FAIL;
                  end
                end
              end
              sdse_pkg::OP_READ: begin
                if (r != sdse_pkg::BYTE_R1_OK) begin
                  phase_nxt = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status = sdse_pkg::ST_READ_REJ;
                end else begin
                  retry_nxt = '0;
                  phase_nxt = PH_TOKEN;
                  poll_nxt  = '0;
                  res.send_byte = sdse_pkg::BYTE_IDLE;
                  res.send_valid = 1'b1;
                  res.chip_select = 1'b1;
                end
              end
              sdse_pkg::OP_WRITE: begin
                phase_nxt = PH_WTOKEN;
                res.send_byte = sdse_pkg::BYTE_TOKEN;
                res.send_valid = 1'b1;
                res.chip_select = 1'b1;
              end
              default: begin
                phase_nxt = PH_STAT_LOW;
                res.send_byte = sdse_pkg::BYTE_IDLE;
                res.send_valid = 1'b1;
                res.chip_select = 1'b1;
              end
            endcase
          end else begin
            poll_nxt = poll_r + 4'd1;
            res.send_byte = sdse_pkg::BYTE_IDLE;
            res.send_valid = 1'b1;
            res.chip_select = 1'b1;
          end
        end
        PH_TOKEN: begin
          if (r != sdse_pkg::BYTE_IDLE) begin
            if (r == sdse_pkg::BYTE_TOKEN) begin
              phase_nxt  = PH_DATA_IN;
              bcount_nxt = '0;
              res.send_byte = sdse_pkg::BYTE_IDLE;
              res.send_valid = 1'b1;
              res.chip_select = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
              res.done_res = 1'b1;
              res.status = sdse_pkg::ST_READ_REJ;
            end
          end else if (!poll_last) begin
            poll_nxt = poll_r + 4'd1;
            res.send_byte = sdse_pkg::BYTE_IDLE;
            res.send_valid = 1'b1;
            res.chip_select = 1'b1;
          end else if (retry_r < cfg.token_tries) begin
            retry_nxt = retry_r + 16'd1;
            poll_nxt  = '0;
            res.send_byte = sdse_pkg::BYTE_IDLE;
            res.send_valid = 1'b1;
            res.chip_select = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
            res.done_res = 1'b1;
            res.status = sdse_pkg::ST_READ_REJ;
          end
        end
        PH_DATA_IN: begin
          if (bcount_w < KW'(kept_r)) begin
            res.read_byte  = r;
            res.read_valid = 1'b1;
            res.read_index = bcount_w[8:0];
          end
          res.send_byte = sdse_pkg::BYTE_IDLE;
          res.send_valid = 1'b1;
          res.chip_select = 1'b1;
          if (bcount_w < LAST_BYTE) begin
            bcount_nxt = bcount_r + CW'(1);
          end else begin
            phase_nxt = PH_TAIL;
            fpos_nxt  = '0;
          end
        end
        PH_WTOKEN: begin
          phase_nxt  = PH_DATA_OUT;
          bcount_nxt = '0;
          res.send_byte = item.write_byte;
          res.send_valid = 1'b1;
          res.chip_select = 1'b1;
          res.write_taken = 1'b1;
        end
        PH_DATA_OUT: begin
          res.send_valid = 1'b1;
          res.chip_select = 1'b1;
          if (bcount_w < LAST_BYTE) begin
            bcount_nxt = bcount_r + CW'(1);
            res.send_byte = item.write_byte;
            res.write_taken = 1'b1;
          end else begin
            phase_nxt = PH_TAIL;
            fpos_nxt  = '0;
            res.send_byte = sdse_pkg::BYTE_IDLE;
          end
        end
        PH_TAIL: begin
          res.send_byte = sdse_pkg::BYTE_IDLE;
          res.send_valid = 1'b1;
          res.chip_select = 1'b1;
          if (fpos_r < 3'd2) fpos_nxt = fpos_r + 3'd1;
          else phase_nxt = PH_BUSY;
        end
        PH_BUSY: begin
          if (r == sdse_pkg::BYTE_IDLE) begin
            phase_nxt = PH_IDLE;
            res.done_res = 1'b1;
            res.status = sdse_pkg::ST_OK;
          end else begin
            res.send_byte = sdse_pkg::BYTE_IDLE;
            res.send_valid = 1'b1;
            res.chip_select = 1'b1;
          end
        end
        PH_STAT_LOW: begin
          phase_nxt = PH_IDLE;
          res.done_res = 1'b1;
          res.status = (sword != 16'd0) ? sdse_pkg::ST_CARD_ERR : sdse_pkg::ST_OK;
          res.card_status = sword;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // state registers, updated once per accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      op_r     <= '0;
      fpos_r   <= '0;
      bcount_r <= '0;
      retry_r  <= '0;
      poll_r   <= '0;
      addr_r   <= '0;
      kept_r   <= '0;
      first_r  <= sdse_pkg::BYTE_IDLE;
      second_r <= 1'b0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      op_r     <= op_nxt;
      fpos_r   <= fpos_nxt;
      bcount_r <= bcount_nxt;
      retry_r  <= retry_nxt;
      poll_r   <= poll_nxt;
      addr_r   <= addr_nxt;
      kept_r   <= kept_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  // a finished operation always returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.done_res |=> phase_r == PH_IDLE)
    else $error("done without return to idle");

  // kept read data only during the data phase
  a_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.read_valid |-> phase_r == PH_DATA_IN)
    else $error("read data outside data phase");

  // write data only goes out as part of an exchange
  a_write_sent: assert property (@(posedge clk) disable iff (!rst_n)
    res.write_taken |-> res.send_valid && res.chip_select)
    else $error("write byte taken without exchange");

  // a card byte while idle causes nothing
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE && item.kind == sdse_pkg::KIND_BYTE |-> res == '0)
    else $error("activity on stray card byte");

endmodule

// ===== hw/rtl/sd_spi_sector_engine_core.sv =====
// SD card SPI-mode host engine: input register, sequencer, result register
// An operation is started by a start transfer; each following input transfer returns the
// byte the card sent on the previous exchange and yields exactly one result naming the next
// byte to send. One transfer is taken per clock unless the result register is stalled: the
// input register feeds the sequencer, whose decision is captured in the result register, so
// throughput is one item per cycle while out_ch.ready keeps the result flowing. Configuration
// writes complete at once and are to be made while no operation is in progress.
`timescale 1ns / 1ps

module sd_spi_sector_engine_core #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic   clk,
  input  logic   rst_n,
  sdse_in_if.sink    in_ch,
  sdse_out_if.source out_ch,
  sdse_cfg_if.sink   cfg_ch
);

  logic                in_valid_r;
  sdse_pkg::in_item_t  in_data_r;
  logic                out_valid_r;
  sdse_pkg::out_item_t out_data_r;
  sdse_pkg::out_item_t seq_res;
  sdse_pkg::cfg_t      cfg_r;
  logic                advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign cfg_ch.ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data_r <= in_ch.data;
    end
  end

  // protocol sequencer
  sdse_seq #(.BLOCK_BYTES(BLOCK_BYTES)) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (in_data_r),
    .cfg   (cfg_r),
    .res   (seq_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= seq_res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_tries <= 10'd100;
      cfg_r.init_tries  <= 16'd32000;
      cfg_r.token_tries <= 16'hFFFF;
      cfg_r.poll_bytes  <= 5'd8;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sdse_pkg::REG_RESET_TRIES: cfg_r.reset_tries <= cfg_ch.data[9:0];
        sdse_pkg::REG_INIT_TRIES:  cfg_r.init_tries  <= cfg_ch.data;
        sdse_pkg::REG_TOKEN_TRIES: cfg_r.token_tries <= cfg_ch.data;
        sdse_pkg::REG_POLL_BYTES:  cfg_r.poll_bytes  <= cfg_ch.data[4:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("result overwritten while stalled");

  // a held input item is either processed or kept
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_data_r))
    else $error("pending input lost");

  // every processed item yields a result the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("missing result");

endmodule
